/* rtl/fupp_pkg.sv */
// shared types, constants and helper functions for the form pair parser
`default_nettype none

package fupp_pkg;

    // default limits on kept raw bytes per pair
    localparam int NAME_MAX_DEF  = 32;
    localparam int VALUE_MAX_DEF = 32;

    // bit width of the name position passed to key matching
    localparam int KEY_POS_W = 6;

    // delimiter characters
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_PERCENT = 8'h25;

    // input item kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // result kinds
    typedef enum logic [1:0] {
        RK_NAME     = 2'd0,
        RK_VALUE    = 2'd1,
        RK_PAIR_END = 2'd2
    } result_kind_t;

    // fixed key table
    localparam int KEY_COUNT = 6;
    localparam int KEY_STR_W = 8 * 13;
    localparam logic [2:0] KEY_NONE = 3'd6;

    localparam logic [KEY_STR_W-1:0] KEY_STR [KEY_COUNT] = '{
        "ssid",
        "password",
        {"mqtt_", "username"},
        {"mqtt_", "password"},
        {"mqtt_", "host"},
        {"mqtt_", "port"}
    };
    localparam logic [3:0] KEY_LEN [KEY_COUNT] = '{4'd4, 4'd8, 4'd13, 4'd13, 4'd9, 4'd9};

    // one result item
    typedef struct packed {
        result_kind_t kind;
        logic [7:0]   data;
        logic [2:0]   key;
        logic         last;
    } result_t;

    // up to three results produced by one input transfer
    typedef struct packed {
        logic [1:0]        count;
        result_t [2:0]     res;
    } burst_t;

    // character c at position pos of key k
    function automatic logic key_match(input int k, input logic [KEY_POS_W-1:0] pos,
                                       input logic [7:0] c);
        logic [3:0] len;
        logic [3:0] sel;
        len = KEY_LEN[k];
        if (pos >= KEY_POS_W'(len)) begin
            return 1'b0;
        end
        // strings are right-justified: first char sits highest
        sel = len - 4'(pos) - 4'd1;
        return KEY_STR[k][{sel, 3'b000} +: 8] == c;
    endfunction

    // hex digit value, 16 when not a hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 5'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = 5'(c - 8'h61 + 8'd10);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 5'(c - 8'h41 + 8'd10);
        end else begin
            v = 5'd16;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

/* rtl/form_urlencoded_pair_parser_core.sv */
// top level of the form body name=value pair parser
//
// Input stream: one transfer per body byte (s_tuser = 0, byte in s_tdata) or an
// end-of-body marker (s_tuser = 1). Output stream: name bytes (m_tuser = 0),
// percent-decoded value bytes (m_tuser = 1) and pair ends (m_tuser = 2, key
// index in m_tdata[10:8]); m_tlast marks the final result of one input item.
// An item gives zero to three results.
// An accepted item is held in the input register, then its results are loaded
// into the result slots, which drive m_tvalid and the output fields.
// One item per cycle is taken while items give at most one result each and
// m_tready stays high; an item that gives two or three results holds the next
// item back while the result register drains to its last entry.
// When m_tready is low, occupied result slots hold and s_tready falls once the
// input register is occupied as well. Reset empties both registers and
// returns the pair state to an empty name with all keys still matching.
`default_nettype none

module form_urlencoded_pair_parser_core #(
    parameter int NAME_MAX  = fupp_pkg::NAME_MAX_DEF,
    parameter int VALUE_MAX = fupp_pkg::VALUE_MAX_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte
    input  wire logic        s_tuser,   // kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // out_byte [7:0], key_index [10:8], zero fill
    output logic [1:0]       m_tuser,   // result_kind
    output logic             m_tlast    // last_of_run
);

    logic              can_take;
    logic              take;
    logic              kind;
    logic [7:0]        data_byte;
    fupp_pkg::burst_t  burst;
    fupp_pkg::result_t head;

    fupp_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_kind    (s_tuser),
        .s_byte    (s_tdata),
        .can_take  (can_take),
        .take      (take),
        .kind      (kind),
        .data_byte (data_byte)
    );

    fupp_decode #(
        .NAME_MAX  (NAME_MAX),
        .VALUE_MAX (VALUE_MAX)
    ) u_dec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (take),
        .kind      (kind),
        .data_byte (data_byte),
        .burst     (burst)
    );

    fupp_out_queue u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .burst    (burst),
        .can_take (can_take),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .head     (head)
    );

    // output field packing
    assign m_tdata = {5'b00000, head.key, head.data};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

`default_nettype wire

/* rtl/fupp_in_stage.sv */
// input register stage for body bytes and end-of-body markers
`default_nettype none

module fupp_in_stage (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic       s_kind,
    input  wire logic [7:0] s_byte,
    input  wire logic       can_take,
    output logic            take,
    output logic            kind,
    output logic [7:0]      data_byte
);

    logic       valid_reg;
    logic       kind_reg;
    logic [7:0] byte_reg;

    // held item moves on when the result side has room
    assign take     = valid_reg && can_take;
    assign s_tready = !valid_reg || take;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            valid_reg <= 1'b1;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            kind_reg <= s_kind;
            byte_reg <= s_byte;
        end
    end

    assign kind      = kind_reg;
    assign data_byte = byte_reg;

endmodule

`default_nettype wire

/* rtl/fupp_decode.sv */
// pair state and single-pass decode of one item into up to three results
`default_nettype none

module fupp_decode #(
    parameter int NAME_MAX  = fupp_pkg::NAME_MAX_DEF,
    parameter int VALUE_MAX = fupp_pkg::VALUE_MAX_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             take,
    input  wire logic             kind,
    input  wire logic [7:0]       data_byte,
    output fupp_pkg::burst_t      burst
);

    localparam int NAME_CW  = $clog2(NAME_MAX + 1);
    localparam int VALUE_CW = $clog2(VALUE_MAX + 1);

    logic                            val_part_reg,  val_part_next;
    logic [NAME_CW-1:0]              name_cnt_reg,  name_cnt_next;
    logic [VALUE_CW-1:0]             value_cnt_reg, value_cnt_next;
    logic [fupp_pkg::KEY_COUNT-1:0]  prefix_reg,    prefix_next;
    logic [1:0]                      held_cnt_reg,  held_cnt_next;
    logic [7:0]                      held_hex_reg,  held_hex_next;

    fupp_pkg::result_t [2:0] res;
    logic [1:0]              n;
    logic [4:0]              h;
    logic [4:0]              hh;
    logic [2:0]              idx;
    logic                    do_pair_end;
    logic                    do_fresh;

    // next state and results
    always_comb begin
        val_part_next  = val_part_reg;
        name_cnt_next  = name_cnt_reg;
        value_cnt_next = value_cnt_reg;
        prefix_next    = prefix_reg;
        held_cnt_next  = held_cnt_reg;
        held_hex_next  = held_hex_reg;
        res            = '0;
        n              = 2'd0;
        do_pair_end    = 1'b0;
        do_fresh       = 1'b0;
        h              = fupp_pkg::hex_val(data_byte);
        hh             = fupp_pkg::hex_val(held_hex_reg);
        idx            = fupp_pkg::KEY_NONE;

        if (kind == fupp_pkg::KIND_END) begin
            if (name_cnt_reg != '0) begin
                do_pair_end = 1'b1;
            end else begin
                val_part_next  = 1'b0;
                name_cnt_next  = '0;
                value_cnt_next = '0;
                prefix_next    = '1;
                held_cnt_next  = 2'd0;
                held_hex_next  = 8'h00;
            end
        end else if (!val_part_reg) begin
            // name part
            if (data_byte == fupp_pkg::CH_EQUAL) begin
                val_part_next  = 1'b1;
                value_cnt_next = '0;
                held_cnt_next  = 2'd0;
                held_hex_next  = 8'h00;
            end else if (name_cnt_reg < NAME_CW'(NAME_MAX)) begin
                res[n] = '{fupp_pkg::RK_NAME, data_byte, 3'd0, 1'b0};
                n      = n + 2'd1;
                for (int k = 0; k < fupp_pkg::KEY_COUNT; k++) begin
                    if (!fupp_pkg::key_match(k, fupp_pkg::KEY_POS_W'(name_cnt_reg),
                                             data_byte)) begin
                        prefix_next[k] = 1'b0;
                    end
                end
                name_cnt_next = name_cnt_reg + NAME_CW'(1);
            end
        end else if (data_byte == fupp_pkg::CH_AMP) begin
            do_pair_end = 1'b1;
        end else if (value_cnt_reg < VALUE_CW'(VALUE_MAX)) begin
            // value part with percent decoding
            value_cnt_next = value_cnt_reg + VALUE_CW'(1);
            if (held_cnt_reg == 2'd1) begin
                if (h < 5'd16) begin
                    held_cnt_next = 2'd2;
                    held_hex_next = data_byte;
                end else begin
                    held_cnt_next = 2'd0;
                    res[n] = '{fupp_pkg::RK_VALUE, fupp_pkg::CH_PERCENT, 3'd0, 1'b0};
                    n      = n + 2'd1;
                    do_fresh = 1'b1;
                end
            end else if (held_cnt_reg == 2'd2) begin
                held_cnt_next = 2'd0;
                held_hex_next = 8'h00;
                if (h < 5'd16) begin
                    res[n] = '{fupp_pkg::RK_VALUE, {hh[3:0], h[3:0]}, 3'd0, 1'b0};
                    n      = n + 2'd1;
                end else begin
                    res[n] = '{fupp_pkg::RK_VALUE, fupp_pkg::CH_PERCENT, 3'd0, 1'b0};
                    n      = n + 2'd1;
                    res[n] = '{fupp_pkg::RK_VALUE, held_hex_reg, 3'd0, 1'b0};
                    n      = n + 2'd1;
                    do_fresh = 1'b1;
                end
            end else begin
                held_cnt_next = 2'd0;
                do_fresh      = 1'b1;
            end

            // breaking or plain byte examined afresh
            if (do_fresh) begin
                if (data_byte == fupp_pkg::CH_PERCENT) begin
                    held_cnt_next = 2'd1;
                end else begin
                    res[n] = '{fupp_pkg::RK_VALUE, data_byte, 3'd0, 1'b0};
                    n      = n + 2'd1;
                end
            end
        end

        // pair end: flush held bytes, report key, clear pair
        if (do_pair_end) begin
            if (held_cnt_reg >= 2'd1) begin
                res[n] = '{fupp_pkg::RK_VALUE, fupp_pkg::CH_PERCENT, 3'd0, 1'b0};
                n      = n + 2'd1;
            end
            if (held_cnt_reg == 2'd2) begin
                res[n] = '{fupp_pkg::RK_VALUE, held_hex_reg, 3'd0, 1'b0};
                n      = n + 2'd1;
            end
            for (int k = fupp_pkg::KEY_COUNT - 1; k >= 0; k--) begin
                if (prefix_reg[k]) begin
                    idx = 3'(k);
                end
            end
            res[n] = '{fupp_pkg::RK_PAIR_END, 8'h00, idx, 1'b0};
            n      = n + 2'd1;
            val_part_next  = 1'b0;
            name_cnt_next  = '0;
            value_cnt_next = '0;
            prefix_next    = '1;
            held_cnt_next  = 2'd0;
            held_hex_next  = 8'h00;
        end

        // mark final result of this item
        if (n != 2'd0) begin
            res[n - 2'd1].last = 1'b1;
        end

        burst.res   = res;
        burst.count = take ? n : 2'd0;
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val_part_reg  <= 1'b0;
            name_cnt_reg  <= '0;
            value_cnt_reg <= '0;
            prefix_reg    <= '1;
            held_cnt_reg  <= 2'd0;
            held_hex_reg  <= 8'h00;
        end else if (take) begin
            val_part_reg  <= val_part_next;
            name_cnt_reg  <= name_cnt_next;
            value_cnt_reg <= value_cnt_next;
            prefix_reg    <= prefix_next;
            held_cnt_reg  <= held_cnt_next;
            held_hex_reg  <= held_hex_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/fupp_out_queue.sv */
// three-slot result register that drains one result per transfer
`default_nettype none

module fupp_out_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire fupp_pkg::burst_t  burst,
    output logic                   can_take,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output fupp_pkg::result_t      head
);

    fupp_pkg::result_t [2:0] slot_reg;
    logic [1:0]              count_reg;
    logic                    pop;

    assign pop      = (count_reg != 2'd0) && m_ready;
    // a new burst lands only when the queue is empty after this cycle
    assign can_take = (count_reg == 2'd0) || (count_reg == 2'd1 && m_ready);
    assign m_valid  = count_reg != 2'd0;
    assign head     = slot_reg[0];

    // occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else if (burst.count != 2'd0) begin
            count_reg <= burst.count;
        end else if (pop) begin
            count_reg <= count_reg - 2'd1;
        end
    end

    // result slots
    always_ff @(posedge aclk) begin
        if (burst.count != 2'd0) begin
            slot_reg <= burst.res;
        end else if (pop) begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// self-checking testbench for the form body name=value pair parser
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NAME_LIMIT   = fupp_pkg::NAME_MAX_DEF;
    localparam int VALUE_LIMIT  = fupp_pkg::VALUE_MAX_DEF;
    localparam int ITEM_TARGET  = 360;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 64;

    // one row of the directed stimulus; typed rows carry their own expectation
    typedef struct packed {
        logic                   kind;
        logic [7:0]             ch;
        logic                   typed;
        logic                   cnt;     // typed rows expect zero or one result
        fupp_pkg::result_kind_t rk;
        logic [7:0]             rb;
        logic [2:0]             rkey;
    } dir_row_t;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_BURSTY
    } rx_mode_t;

    localparam dir_row_t DIR_ROWS [26] = '{
        '{fupp_pkg::KIND_END, 8'h00, 1'b1, 1'b0, fupp_pkg::RK_NAME, 8'h00, 3'd0},
        '{fupp_pkg::KIND_BYTE, fupp_pkg::CH_EQUAL, 1'b1, 1'b0, fupp_pkg::RK_NAME, 8'h00, 3'd0},
        '{fupp_pkg::KIND_BYTE, fupp_pkg::CH_AMP, 1'b1, 1'b1, fupp_pkg::RK_PAIR_END, 8'h00,
          3'd0},
        '{fupp_pkg::KIND_BYTE, "s", 1'b1, 1'b1, fupp_pkg::RK_NAME, "s", 3'd0},
        '{fupp_pkg::KIND_BYTE, "s", 1'b0, 1'b0, fupp_pkg::RK_NAME, 8'h00, 3'd0},
        '{fupp_pkg::KIND_BYTE, "i", 1'b0, 1'b0, fupp_pkg::RK_NAME, 8'h00, 3'd0},
        '{fupp_pkg::KIND_BYTE, "d", 1'b0, 1'b0, fupp_pkg::RK_NAME, 8'h00, 3'd0},
        '{fupp_pkg::KIND_BYTE, fupp_pkg::CH_EQUAL, 1'b1, 1'b0, fupp_pkg::RK_NAME, 8'h00, 3'd0},
        '{fupp_pkg::KIND_BYTE, fupp_pkg::CH_PERCENT, 1'b1, 1'b0, fupp_pkg::RK_NAME, 8'h00,
          3'd0},
        '{fupp_pkg::KIND_BYTE, "4", 1'b1, 1'b0, fupp_pkg::RK_NAME, 8'h00, 3'd0},
        '{fupp_pkg::KIND_BYTE, "1", 1'b0, 1'b0, fupp_pkg::RK_NAME, 8'h00, 3'd0},
        '{fupp_pkg::KIND_BYTE, fupp_pkg::CH_PERCENT, 1'b0, 1'b0, fupp_pkg::RK_NAME, 8'h00,
          3'd0},
        '{fupp_pkg::KIND_BYTE, "G", 1'b0, 1'b0, fupp_pkg::RK_NAME, 8'h00, 3'd0},
        '{fupp_pkg::KIND_BYTE, fupp_pkg::CH_PERCENT, 1'b0, 1'b0, fupp_pkg::RK_NAME, 8'h00,
          3'd0},
        '{fupp_pkg::KIND_BYTE, "a", 1'b0, 1'b0, fupp_pkg::RK_NAME, 8'h00, 3'd0},
        '{fupp_pkg::KIND_BYTE, fupp_pkg::CH_PERCENT, 1'b0, 1'b0, fupp_pkg::RK_NAME, 8'h00,
          3'd0},
        '{fupp_pkg::KIND_BYTE, "F", 1'b0, 1'b0, fupp_pkg::RK_NAME, 8'h00, 3'd0},
        '{fupp_pkg::KIND_END, 8'hFF, 1'b0, 1'b0, fupp_pkg::RK_NAME, 8'h00, 3'd0},
        '{fupp_pkg::KIND_BYTE, 8'h00, 1'b1, 1'b1, fupp_pkg::RK_NAME, 8'h00, 3'd0},
        '{fupp_pkg::KIND_BYTE, 8'hFF, 1'b1, 1'b1, fupp_pkg::RK_NAME, 8'hFF, 3'd0},
        '{fupp_pkg::KIND_BYTE, fupp_pkg::CH_AMP, 1'b1, 1'b1, fupp_pkg::RK_NAME,
          fupp_pkg::CH_AMP, 3'd0},
        '{fupp_pkg::KIND_END, 8'h00, 1'b1, 1'b1, fupp_pkg::RK_PAIR_END, 8'h00,
          fupp_pkg::KEY_NONE},
        '{fupp_pkg::KIND_BYTE, "p", 1'b0, 1'b0, fupp_pkg::RK_NAME, 8'h00, 3'd0},
        '{fupp_pkg::KIND_BYTE, fupp_pkg::CH_EQUAL, 1'b0, 1'b0, fupp_pkg::RK_NAME, 8'h00, 3'd0},
        '{fupp_pkg::KIND_BYTE, fupp_pkg::CH_EQUAL, 1'b1, 1'b1, fupp_pkg::RK_VALUE,
          fupp_pkg::CH_EQUAL, 3'd0},
        '{fupp_pkg::KIND_BYTE, fupp_pkg::CH_AMP, 1'b0, 1'b0, fupp_pkg::RK_NAME, 8'h00, 3'd0}
    };

    string key_names [fupp_pkg::KEY_COUNT] = '{"ssid", "password", {"mqtt_", "username"},
                                               {"mqtt_", "password"}, {"mqtt_", "host"},
                                               {"mqtt_", "port"}};

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // data_byte
    logic        s_tuser  = 1'b0;    // kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // out_byte [7:0], key_index [10:8], zero fill
    logic [1:0]  m_tuser;            // result_kind
    logic        m_tlast;

    // decoder state mirrored by the predictor
    logic       value_part;
    logic [5:0] name_cnt;
    logic [5:0] value_cnt;
    logic [5:0] key_live;
    logic [1:0] pct_held;
    logic [7:0] pct_digit;

    fupp_pkg::result_t step_res [$];     // results of the item being predicted
    fupp_pkg::result_t pending_res [$];  // results still awaited from the block
    fupp_pkg::result_t want;
    int       errors = 0;
    int       idle_cycles = 0;
    int       items_sent = 0;
    int       burst_left = 0;
    rx_mode_t rx_mode = RX_FREE;
    int       rx_left = 0;
    int       rx_phase = 0;

    form_urlencoded_pair_parser_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------- predictor ----------------

    function automatic void put_res(fupp_pkg::result_kind_t k, logic [7:0] b, logic [2:0] key);
        fupp_pkg::result_t r;
        r.kind = k;
        r.data = b;
        r.key  = key;
        r.last = 1'b0;
        step_res.push_back(r);
    endfunction

    // hex digit to nibble, bit 4 set when the byte is no hex digit
    function automatic logic [4:0] hex_nibble(logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return {1'b0, c[3:0]};
        end
        if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
            return {1'b0, c[3:0] + 4'd9};
        end
        return 5'h10;
    endfunction

    function automatic void clear_pair();
        value_part = 1'b0;
        name_cnt   = '0;
        value_cnt  = '0;
        key_live   = '1;
        pct_held   = '0;
        pct_digit  = '0;
    endfunction

    function automatic void value_start(logic [7:0] c);
        if (c == fupp_pkg::CH_PERCENT) begin
            pct_held = 2'd1;
        end else begin
            put_res(fupp_pkg::RK_VALUE, c, 3'd0);
        end
    endfunction

    // percent decoding of one kept value byte
    function automatic void value_take(logic [7:0] c);
        logic [4:0] lo;
        logic [4:0] hi;
        lo = hex_nibble(c);
        hi = hex_nibble(pct_digit);
        case (pct_held)
            2'd1: begin
                if (!lo[4]) begin
                    pct_held  = 2'd2;
                    pct_digit = c;
                end else begin
                    pct_held = 2'd0;
                    put_res(fupp_pkg::RK_VALUE, fupp_pkg::CH_PERCENT, 3'd0);
                    value_start(c);
                end
            end
            2'd2: begin
                pct_held = 2'd0;
                if (!lo[4]) begin
                    put_res(fupp_pkg::RK_VALUE, {hi[3:0], lo[3:0]}, 3'd0);
                end else begin
                    put_res(fupp_pkg::RK_VALUE, fupp_pkg::CH_PERCENT, 3'd0);
                    put_res(fupp_pkg::RK_VALUE, pct_digit, 3'd0);
                    value_start(c);
                end
                pct_digit = '0;
            end
            default: begin
                pct_held = 2'd0;
                value_start(c);
            end
        endcase
    endfunction

    // flush held percent bytes and report the first key still matching
    function automatic void close_pair();
        logic [2:0] idx;
        idx = fupp_pkg::KEY_NONE;
        if (pct_held != 2'd0) begin
            put_res(fupp_pkg::RK_VALUE, fupp_pkg::CH_PERCENT, 3'd0);
        end
        if (pct_held == 2'd2) begin
            put_res(fupp_pkg::RK_VALUE, pct_digit, 3'd0);
        end
        for (int k = fupp_pkg::KEY_COUNT - 1; k >= 0; k--) begin
            if (key_live[k]) begin
                idx = 3'(k);
            end
        end
        put_res(fupp_pkg::RK_PAIR_END, 8'h00, idx);
        clear_pair();
    endfunction

    function automatic void name_take(logic [7:0] c);
        put_res(fupp_pkg::RK_NAME, c, 3'd0);
        for (int k = 0; k < fupp_pkg::KEY_COUNT; k++) begin
            if (int'(name_cnt) >= key_names[k].len() || 8'(key_names[k][name_cnt]) != c) begin
                key_live[k] = 1'b0;
            end
        end
        name_cnt = name_cnt + 6'd1;
    endfunction

    // results of one input item
    function automatic void parse_item(logic kind, logic [7:0] c);
        step_res.delete();
        if (kind == fupp_pkg::KIND_END) begin
            if (name_cnt != 0) begin
                close_pair();
            end else begin
                clear_pair();
            end
        end else if (!value_part) begin
            if (c == fupp_pkg::CH_EQUAL) begin
                value_part = 1'b1;
                value_cnt  = '0;
                pct_held   = '0;
                pct_digit  = '0;
            end else if (int'(name_cnt) < NAME_LIMIT) begin
                name_take(c);
            end
        end else if (c == fupp_pkg::CH_AMP) begin
            close_pair();
        end else if (int'(value_cnt) < VALUE_LIMIT) begin
            value_cnt = value_cnt + 6'd1;
            value_take(c);
        end
    endfunction

    // ---------------- input side ----------------

    // send one item in bursts with random gaps, then predict its results
    task automatic send_item(dir_row_t r);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= r.kind;
        s_tdata  <= r.ch;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        parse_item(r.kind, r.ch);
        if (r.typed) begin
            step_res.delete();
            if (r.cnt) begin
                put_res(r.rk, r.rb, r.rkey);
            end
        end
        if (step_res.size() != 0) begin
            step_res[step_res.size() - 1].last = 1'b1;
        end
        foreach (step_res[i]) begin
            pending_res.push_back(step_res[i]);
        end
    endtask

    task automatic send_byte(logic [7:0] c);
        dir_row_t r;
        r = '0;
        r.kind = fupp_pkg::KIND_BYTE;
        r.ch   = c;
        send_item(r);
    endtask

    task automatic send_end();
        dir_row_t r;
        r = '0;
        r.kind = fupp_pkg::KIND_END;
        r.ch   = 8'($urandom_range(0, 255));
        send_item(r);
    endtask

    function automatic logic [7:0] rand_hex();
        string digits;
        digits = "0123456789abcdefABCDEF";
        return 8'(digits[$urandom_range(0, 21)]);
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] c;
        logic [4:0] h;
        do begin
            c = 8'($urandom_range(0, 255));
            h = hex_nibble(c);
        end while (!h[4] || c == fupp_pkg::CH_AMP);
        return c;
    endfunction

    function automatic logic [7:0] rand_name_char(bit full_range);
        logic [7:0] c;
        do begin
            c = full_range ? 8'($urandom_range(0, 255)) : 8'($urandom_range(97, 122));
        end while (c == fupp_pkg::CH_EQUAL);
        return c;
    endfunction

    // one pair with random content; some end at an end marker before the '=' sign
    task automatic gen_pair();
        int mode;
        int n;
        int k;
        int piece;
        logic [7:0] c;
        mode = $urandom_range(0, 9);
        n = 0;
        if (mode <= 4) begin
            // a known key, sometimes cut short or with extra characters
            k = $urandom_range(0, fupp_pkg::KEY_COUNT - 1);
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, key_names[k].len())
                                            : key_names[k].len();
            for (int i = 0; i < n; i++) begin
                send_byte(8'(key_names[k][i]));
            end
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        end else if (mode <= 6) begin
            n = $urandom_range(0, 6);
        end else if (mode == 7) begin
            n = $urandom_range(NAME_LIMIT - 2, NAME_LIMIT + 8);
        end else if (mode == 8) begin
            n = $urandom_range(1, 5);
        end
        for (int i = 0; i < n; i++) begin
            send_byte(rand_name_char(mode >= 7));
        end
        if ($urandom_range(0, 9) == 0) begin
            send_end();
            return;
        end
        send_byte(fupp_pkg::CH_EQUAL);
        // value with percent sequences, good and broken
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(VALUE_LIMIT - 4, VALUE_LIMIT + 8)
                                        : $urandom_range(0, 10);
        for (int i = 0; i < n; i++) begin
            piece = $urandom_range(0, 9);
            case (piece)
                0, 1, 2, 3: send_byte(8'($urandom_range(48, 122)));
                4, 5: begin
                    send_byte(fupp_pkg::CH_PERCENT);
                    send_byte(rand_hex());
                    send_byte(rand_hex());
                end
                6: begin
                    send_byte(fupp_pkg::CH_PERCENT);
                    send_byte(rand_non_hex());
                end
                7: begin
                    send_byte(fupp_pkg::CH_PERCENT);
                    send_byte(rand_hex());
                    send_byte(rand_non_hex());
                end
                8: begin
                    do c = 8'($urandom_range(0, 255)); while (c == fupp_pkg::CH_AMP);
                    send_byte(c);
                end
                default: send_byte(fupp_pkg::CH_PERCENT);
            endcase
        end
        if ($urandom_range(0, 5) == 0) begin
            send_end();
        end else begin
            send_byte(fupp_pkg::CH_AMP);
        end
    endtask

    // stimulus, drain and final verdict
    initial begin
        clear_pair();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (DIR_ROWS[i]) begin
            send_item(DIR_ROWS[i]);
        end

        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise: arbitrary bytes and end markers
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(0, 4) == 0) begin
                        send_end();
                    end else begin
                        send_byte(8'($urandom_range(0, 255)));
                    end
                end
            end else begin
                gen_pair();
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (pending_res.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (m_tvalid) begin
            $error("m_tvalid: expected 0, actual 1");
            errors++;
        end
        if (errors == 0) begin
            $display("form_urlencoded_pair_parser_core test passed");
        end else begin
            $display("form_urlencoded_pair_parser_core test failed");
        end
        $finish;
    end

    // ---------------- output side ----------------

    // receiver ready pattern, switching between stall styles
    always @(negedge aclk) begin
        rx_phase <= rx_phase + 1;
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 150);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_FREE:  m_tready <= 1'b1;
            RX_LIGHT: m_tready <= ($urandom_range(0, 9) < 7);
            RX_HEAVY: m_tready <= ($urandom_range(0, 9) < 3);
            default:  m_tready <= (rx_phase % 16) >= 12;
        endcase
    end

    // compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_res.size() == 0) begin
                $error("unexpected result: kind %0d byte %02h key %0d last %0d",
                       m_tuser, m_tdata[7:0], m_tdata[10:8], m_tlast);
                errors++;
            end else begin
                want = pending_res.pop_front();
                if (m_tuser != want.kind) begin
                    $error("result_kind: expected %0d, actual %0d", want.kind, m_tuser);
                    errors++;
                end
                if (m_tdata[7:0] != want.data) begin
                    $error("out_byte: expected %02h, actual %02h", want.data, m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[10:8] != want.key) begin
                    $error("key_index: expected %0d, actual %0d", want.key, m_tdata[10:8]);
                    errors++;
                end
                if (m_tlast != want.last) begin
                    $error("last_of_run: expected %0d, actual %0d", want.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("form_urlencoded_pair_parser_core test failed");
            $finish;
        end
    end

endmodule
